// File: src/ordered_list_move_after_unit_assert.svh
// ----------------------------------------------------------------------------
// ordered list move-after unit: assertion macros
// shared property forms for the concurrent checks of the design
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_MOVE_AFTER_UNIT_ASSERT_SVH
`define ORDERED_LIST_MOVE_AFTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define OLM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olm check failed");

// next-cycle implication, disabled in reset
`define OLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olm check failed");

`endif

// File: src/olm_pkg.sv
// ----------------------------------------------------------------------------
// olm_pkg
// types, constants and the microcode table of the ordered list move-after unit
// ----------------------------------------------------------------------------
package olm_pkg;

   localparam int MAX_ELEMS = 64;
   localparam int DEPTH     = MAX_ELEMS + 1;
   localparam int ID_W      = 7;

   // sequencer steps
   localparam logic [2:0] STEP_IDLE     = 3'd0;
   localparam logic [2:0] STEP_M_READ_E = 3'd1;
   localparam logic [2:0] STEP_M_UNLINK = 3'd2;
   localparam logic [2:0] STEP_M_LINK_A = 3'd3;
   localparam logic [2:0] STEP_M_LINK_E = 3'd4;
   localparam logic [2:0] STEP_Q_START  = 3'd5;
   localparam logic [2:0] STEP_Q_WALK   = 3'd6;

   typedef enum logic [2:0] {
      RD_NONE, RD_ELEM, RD_ANCHOR, RD_HEAD, RD_CHAIN
   } rd_sel_type;

   typedef enum logic [1:0] {
      WN_NONE, WN_UNLINK, WN_ANCHOR, WN_ELEM
   } wn_sel_type;

   typedef enum logic [1:0] {
      WP_NONE, WP_UNLINK, WP_ELEM, WP_SUCC
   } wp_sel_type;

   typedef enum logic [1:0] {
      SQ_NEXT, SQ_DISPATCH, SQ_WALK, SQ_HOME
   } seq_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wn_sel_type wn_sel;
      wp_sel_type wp_sel;
      logic       ld_pn;
      logic       ld_s;
      logic       ld_rem;
      seq_type    seq;
   } ucode_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
      logic [ID_W-1:0] data;
   } link_wr_type;

   function automatic ucode_type ucode_rom(input logic [2:0] step);
      ucode_type uw;
      uw = '{rd_sel: RD_NONE, wn_sel: WN_NONE, wp_sel: WP_NONE,
             ld_pn: 1'b0, ld_s: 1'b0, ld_rem: 1'b0, seq: SQ_HOME};
      unique case (step)
         STEP_IDLE: begin
            uw.seq = SQ_DISPATCH;
         end
         STEP_M_READ_E: begin
            uw.rd_sel = RD_ELEM;
            uw.seq    = SQ_NEXT;
         end
         STEP_M_UNLINK: begin
            uw.rd_sel = RD_ANCHOR;
            uw.wn_sel = WN_UNLINK;
            uw.wp_sel = WP_UNLINK;
            uw.ld_pn  = 1'b1;
            uw.seq    = SQ_NEXT;
         end
         STEP_M_LINK_A: begin
            uw.wn_sel = WN_ANCHOR;
            uw.wp_sel = WP_ELEM;
            uw.ld_s   = 1'b1;
            uw.seq    = SQ_NEXT;
         end
         STEP_M_LINK_E: begin
            uw.wn_sel = WN_ELEM;
            uw.wp_sel = WP_SUCC;
            uw.seq    = SQ_HOME;
         end
         STEP_Q_START: begin
            uw.rd_sel = RD_HEAD;
            uw.ld_rem = 1'b1;
            uw.seq    = SQ_NEXT;
         end
         STEP_Q_WALK: begin
            uw.rd_sel = RD_CHAIN;
            uw.seq    = SQ_WALK;
         end
         default: begin
            uw.seq = SQ_HOME;
         end
      endcase
      return uw;
   endfunction

   // order after reset or a count write: 0 -> 1 -> ... -> count -> 0
   function automatic logic [ID_W-1:0] next_init(input logic [ID_W-1:0] k,
                                                 input logic [ID_W-1:0] cnt);
      return (k < cnt) ? ID_W'(k + 1'b1) : '0;
   endfunction

   function automatic logic [ID_W-1:0] prev_init(input logic [ID_W-1:0] k,
                                                 input logic [ID_W-1:0] cnt);
      logic [ID_W-1:0] r;
      if (k == '0) begin
         r = cnt;
      end else if (k <= cnt) begin
         r = ID_W'(k - 1'b1);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// File: src/ordered_list_move_after_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_move_after_unit
// keeps the order of ids 1..count as a doubly linked ring; moves and queries
// ----------------------------------------------------------------------------
// The unit takes one command at a time. A move (tuser 0) relocates
// elem_to_move directly after anchor_elem and returns nothing; it occupies
// the unit through the steps M_READ_E, M_UNLINK, M_LINK_A and M_LINK_E, set
// by the dependent pointer reads and writes through the single write port of
// each link memory. A move with equal ids or an id outside 1..count is
// dropped in the accept cycle. A query (tuser 1) returns every id in list
// order, tlast on the final one, at one item per cycle when the result side
// keeps up. Writing the count register (0 becomes 1, above 64 becomes 64)
// restores the order 1..count, as reset does; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "ordered_list_move_after_unit_assert.svh"

module ordered_list_move_after_unit
   import olm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // element_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // elem_to_move [6:0], anchor_elem [13:7], zero
   input  logic        req_tuser,     // command: 0 move, 1 query
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // elem_value [6:0], zero
   output logic        rsp_tlast
);

   logic [2:0]      upc_ff, upc_in;
   logic [ID_W-1:0] count_ff;
   logic [ID_W-1:0] elem_ff, anchor_ff;
   logic [ID_W-1:0] p_ff, n_ff, s_ff;
   logic [ID_W-1:0] rem_ff;
   logic            rsp_vld_ff;
   logic [ID_W-1:0] rsp_val_ff;
   logic            rsp_last_ff;

   ucode_type       uw;
   logic            req_acc;
   logic [ID_W-1:0] req_elem, req_anchor;
   logic            move_ok;
   logic            out_free;
   logic            emit;
   logic [ID_W-1:0] cnt_wr;
   logic            rd_en;
   logic [ID_W-1:0] rd_addr;
   logic [ID_W-1:0] rd_next, rd_prev;
   logic [ID_W-1:0] s_in;
   link_wr_type     wr_next, wr_prev;

   assign uw         = ucode_rom(upc_ff);
   assign req_tready = (upc_ff == STEP_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_elem   = req_tdata[6:0];
   assign req_anchor = req_tdata[13:7];
   assign move_ok    = (req_elem != req_anchor) &&
                       (req_elem != '0) && (req_elem <= count_ff) &&
                       (req_anchor != '0) && (req_anchor <= count_ff);
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign emit       = (uw.seq == SQ_WALK) && out_free;

   always_comb begin
      if (csr_wr_data == '0) begin
         cnt_wr = ID_W'(1);
      end else if (csr_wr_data > ID_W'(MAX_ELEMS)) begin
         cnt_wr = ID_W'(MAX_ELEMS);
      end else begin
         cnt_wr = csr_wr_data;
      end
   end

   // read port: the walk only advances when the result register can take an item
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      case (uw.rd_sel)
         RD_ELEM:   rd_addr = elem_ff;
         RD_ANCHOR: rd_addr = anchor_ff;
         RD_HEAD:   rd_addr = '0;
         RD_CHAIN: begin
            rd_addr = rd_next;
            rd_en   = out_free;
         end
         default:   rd_en = 1'b0;
      endcase
   end

   // unlink wrote next[p] in the same cycle next[anchor] was read
   assign s_in = (anchor_ff == p_ff) ? n_ff : rd_next;

   always_comb begin
      wr_next = '0;
      wr_prev = '0;
      case (uw.wn_sel)
         WN_UNLINK: wr_next = '{en: 1'b1, addr: rd_prev, data: rd_next};
         WN_ANCHOR: wr_next = '{en: 1'b1, addr: anchor_ff, data: elem_ff};
         WN_ELEM:   wr_next = '{en: 1'b1, addr: elem_ff, data: s_ff};
         default:   wr_next = '0;
      endcase
      case (uw.wp_sel)
         WP_UNLINK: wr_prev = '{en: 1'b1, addr: rd_next, data: rd_prev};
         WP_ELEM:   wr_prev = '{en: 1'b1, addr: elem_ff, data: anchor_ff};
         WP_SUCC:   wr_prev = '{en: 1'b1, addr: s_ff, data: elem_ff};
         default:   wr_prev = '0;
      endcase
   end

   always_comb begin
      unique case (uw.seq)
         SQ_NEXT: upc_in = 3'(upc_ff + 1'b1);
         SQ_DISPATCH: begin
            if (req_acc && req_tuser) begin
               upc_in = STEP_Q_START;
            end else if (req_acc && move_ok) begin
               upc_in = STEP_M_READ_E;
            end else begin
               upc_in = STEP_IDLE;
            end
         end
         SQ_WALK: upc_in = (emit && rem_ff == ID_W'(1)) ? STEP_IDLE : upc_ff;
         SQ_HOME: upc_in = STEP_IDLE;
         default: upc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff     <= STEP_IDLE;
         rsp_vld_ff <= 1'b0;
         count_ff   <= ID_W'(MAX_ELEMS);
      end else begin
         upc_ff <= upc_in;
         if (csr_wr_en) begin
            count_ff <= cnt_wr;
         end
         if (emit) begin
            rsp_vld_ff  <= 1'b1;
            rsp_val_ff  <= rd_next;
            rsp_last_ff <= (rem_ff == ID_W'(1));
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (req_acc) begin
            elem_ff   <= req_elem;
            anchor_ff <= req_anchor;
         end
         if (uw.ld_pn) begin
            p_ff <= rd_prev;
            n_ff <= rd_next;
         end
         if (uw.ld_s) begin
            s_ff <= s_in;
         end
         if (uw.ld_rem) begin
            rem_ff <= count_ff;
         end else if (emit) begin
            rem_ff <= ID_W'(rem_ff - 1'b1);
         end
      end
   end

   olm_link_table u_links (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_wr_en),
      .count   (count_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .rd_next (rd_next),
      .rd_prev (rd_prev)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff};
   assign rsp_tlast  = rsp_last_ff;

   `OLM_ASSERT_NOW(a_rsp_from_walk, clock, reset, $rose(rsp_vld_ff), $past(upc_ff == STEP_Q_WALK))
   `OLM_ASSERT_NOW(a_walk_rem_nonzero, clock, reset, upc_ff == STEP_Q_WALK, rem_ff != '0)
   `OLM_ASSERT_NOW(a_next_wr_in_range, clock, reset, wr_next.en, wr_next.addr <= count_ff)
   `OLM_ASSERT_NOW(a_prev_wr_in_range, clock, reset, wr_prev.en, wr_prev.addr <= count_ff)
   `OLM_ASSERT_NEXT(a_move_returns, clock, reset, upc_ff == STEP_M_LINK_E, upc_ff == STEP_IDLE)

endmodule

// File: src/olm_link_table.sv
// ----------------------------------------------------------------------------
// olm_link_table
// successor and predecessor pointer memories, one write port each, one shared
// read address, registered read data; per-entry valid bits stand in for the
// initial ring, so that a clear resets only the valid bits, in the clear cycle
// ----------------------------------------------------------------------------
module olm_link_table
   import olm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  logic [ID_W-1:0] count,
   input  logic            rd_en,
   input  logic [ID_W-1:0] rd_addr,
   input  link_wr_type     wr_next,
   input  link_wr_type     wr_prev,
   output logic [ID_W-1:0] rd_next,
   output logic [ID_W-1:0] rd_prev
);

   logic [ID_W-1:0] next_mem [DEPTH];
   logic [ID_W-1:0] prev_mem [DEPTH];

   logic [DEPTH-1:0] next_vld_ff;
   logic [DEPTH-1:0] prev_vld_ff;

   logic [ID_W-1:0] rd_next_ff;
   logic [ID_W-1:0] rd_prev_ff;
   logic [ID_W-1:0] rd_addr_ff;
   logic            rd_next_vld_ff;
   logic            rd_prev_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_next.en) begin
         next_mem[wr_next.addr] <= wr_next.data;
      end
      if (wr_prev.en) begin
         prev_mem[wr_prev.addr] <= wr_prev.data;
      end
      if (rd_en) begin
         rd_next_ff     <= next_mem[rd_addr];
         rd_prev_ff     <= prev_mem[rd_addr];
         rd_next_vld_ff <= next_vld_ff[rd_addr];
         rd_prev_vld_ff <= prev_vld_ff[rd_addr];
         rd_addr_ff     <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         next_vld_ff <= '0;
         prev_vld_ff <= '0;
      end else begin
         if (wr_next.en) begin
            next_vld_ff[wr_next.addr] <= 1'b1;
         end
         if (wr_prev.en) begin
            prev_vld_ff[wr_prev.addr] <= 1'b1;
         end
      end
   end

   // entries never written read as the initial ring
   assign rd_next = rd_next_vld_ff ? rd_next_ff : next_init(rd_addr_ff, count);
   assign rd_prev = rd_prev_vld_ff ? rd_prev_ff : prev_init(rd_addr_ff, count);

endmodule
